FILE: sv/wpf_pkg.sv
// Shared constants and types for the waypoint path-following step core.
package wpf_pkg;

  // Waypoint ring
  localparam int MAX_WP  = 16;
  localparam int WP_AW   = $clog2(MAX_WP);
  localparam int CNT_MAX = (MAX_WP < 16) ? MAX_WP : 16;

  // Register port
  localparam int ADDR_W = 4;
  localparam logic [30:0] ARRIVAL_RST = 31'd3276800;
  localparam logic [30:0] SLOWING_RST = 31'd13107200;
  localparam logic [4:0]  COUNT_RST   = 5'd1;

  typedef enum logic [1:0] {
    REG_ARRIVAL = 2'd0,
    REG_SLOWING = 2'd1,
    REG_COUNT   = 2'd2
  } reg_idx_e;

  // Item kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Square root unit: one root bit per stage
  localparam int SQ_RADW  = 68;
  localparam int SQ_ROOTW = SQ_RADW / 2;
  localparam int SQ_REMW  = SQ_ROOTW + 3;
  localparam int SQ_LAT   = SQ_ROOTW;

  // Divider unit: one quotient bit per stage
  localparam int DIV_NUMW = 64;
  localparam int DIV_DENW = 34;
  localparam int DIV_QW   = 31;
  localparam int DIV_LAT  = DIV_QW;

endpackage

FILE: sv/waypoint_path_following_step_core.sv
// Path-following steering step with arrival slowdown over a waypoint ring.
//
// Input channel (in_valid_i/in_ready_o): one beat is a load (writes one
// waypoint slot) or a step (one agent update). Output channel
// (out_valid_o/out_ready_i): one result beat per input beat, in order; load
// beats return all-zero fields. An APB-style port writes arrival radius
// (0x0), slowing radius (0x4) and waypoint count (0x8); pready is tied high.
// Throughput: one beat per cycle while the output is not held. Each beat
// passes in turn through two 34-stage square-root pipelines, three 31-stage
// divider pipelines and 19 arithmetic stages.
// The whole pipeline advances together: when the output beat is held
// (out_valid_o high, out_ready_i low) every stage holds and in_ready_o drops;
// no beat is lost or repeated.
// Reset clears all valid bits and loads the register defaults; waypoint
// table contents stay unknown until written by load beats.
module waypoint_path_following_step_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [3:0]                 waypoint_index_i,
  input  logic signed [31:0]         pos_x_i,
  input  logic signed [31:0]         pos_y_i,
  input  logic signed [31:0]         vel_x_i,
  input  logic signed [31:0]         vel_y_i,
  input  logic [30:0]                max_speed_i,
  input  logic [17:0]                delta_time_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         new_pos_x_o,
  output logic signed [31:0]         new_pos_y_o,
  output logic signed [31:0]         new_vel_x_o,
  output logic signed [31:0]         new_vel_y_o,
  output logic [3:0]                 next_waypoint_index_o,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wpf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wpf_pkg::*;

  // ---------------------------------------------------------------------
  // Stage payload types
  typedef struct packed {
    logic        vld;
    logic        func;
    logic [3:0]  idx0;
    logic [3:0]  idx1;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [30:0] maxs;
    logic [17:0] dt;
  } s1_t;

  typedef struct packed {
    logic        vld;
    logic        func;
    logic [3:0]  idx0;
    logic [3:0]  idx1;
    logic [32:0] dx0;
    logic [32:0] dy0;
    logic [32:0] dx1;
    logic [32:0] dy1;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [30:0] maxs;
    logic [17:0] dt;
  } a_t;

  typedef struct packed {
    logic        vld;
    logic        func;
    logic [3:0]  idx;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [33:0] len;
    logic        sl;
    logic [30:0] speed;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [30:0] maxs;
    logic [17:0] dt;
  } b_t;

  typedef struct packed {
    logic        vld;
    logic        func;
    logic [3:0]  idx;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [30:0] maxs;
    logic [17:0] dt;
  } e_t;

  typedef struct packed {
    logic        vld;
    logic        func;
    logic [3:0]  idx;
    logic [33:0] nx;
    logic [33:0] ny;
    logic        clamp;
    logic [31:0] px;
    logic [31:0] py;
    logic [30:0] maxs;
    logic [17:0] dt;
  } g_t;

  typedef struct packed {
    logic        vld;
    logic        func;
    logic [3:0]  idx;
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] px;
    logic [31:0] py;
    logic [17:0] dt;
  } i_t;

  // magnitude helpers
  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = v[32] ? (33'd0 - v) : v;
    return n[31:0];
  endfunction

  function automatic logic [32:0] mag34(input logic [33:0] v);
    logic [33:0] n;
    n = v[33] ? (34'd0 - v) : v;
    return n[32:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat35(input logic [34:0] v);
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      return v[31:0];
    end
    return v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  logic en;

  // ---------------------------------------------------------------------
  // Configuration registers
  logic [30:0] arrival_q;
  logic [30:0] slowing_q;
  logic [4:0]  count_q;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q <= ARRIVAL_RST;
      slowing_q <= SLOWING_RST;
      count_q   <= COUNT_RST;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[ADDR_W-1:2]))
        REG_ARRIVAL: arrival_q <= pwdata[30:0];
        REG_SLOWING: slowing_q <= pwdata[30:0];
        REG_COUNT:   count_q   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[ADDR_W-1:2]))
      REG_ARRIVAL: prdata = {1'b0, arrival_q};
      REG_SLOWING: prdata = {1'b0, slowing_q};
      REG_COUNT:   prdata = {27'd0, count_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Ring index selection and waypoint table
  logic [4:0]       cnt;
  logic [3:0]       idx0;
  logic [4:0]       idx_inc;
  logic [3:0]       idx1;
  logic [31:0]      wpx_mem [MAX_WP];
  logic [31:0]      wpy_mem [MAX_WP];
  logic [31:0]      wpa_x_q, wpa_y_q, wpb_x_q, wpb_y_q;
  logic             wr_en;

  always_comb begin
    if (count_q == 5'd0) begin
      cnt = 5'd1;
    end else if (count_q > 5'(CNT_MAX)) begin
      cnt = 5'(CNT_MAX);
    end else begin
      cnt = count_q;
    end
    idx0    = ({1'b0, waypoint_index_i} >= cnt) ? 4'd0 : waypoint_index_i;
    idx_inc = {1'b0, idx0} + 5'd1;
    idx1    = (idx_inc >= cnt) ? 4'd0 : idx_inc[3:0];
  end

  assign wr_en = en && in_valid_i && (func_i == FUNC_LOAD) &&
                 (32'(waypoint_index_i) < MAX_WP);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wpx_mem[WP_AW'(waypoint_index_i)] <= pos_x_i;
      wpy_mem[WP_AW'(waypoint_index_i)] <= pos_y_i;
    end
    if (en) begin
      wpa_x_q <= wpx_mem[WP_AW'(idx0)];
      wpa_y_q <= wpy_mem[WP_AW'(idx0)];
      wpb_x_q <= wpx_mem[WP_AW'(idx1)];
      wpb_y_q <= wpy_mem[WP_AW'(idx1)];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: capture the beat
  s1_t s1_d, s1_q;

  always_comb begin
    s1_d      = '0;
    s1_d.vld  = in_valid_i;
    s1_d.func = func_i;
    s1_d.idx0 = idx0;
    s1_d.idx1 = idx1;
    s1_d.px   = pos_x_i;
    s1_d.py   = pos_y_i;
    s1_d.vx   = vel_x_i;
    s1_d.vy   = vel_y_i;
    s1_d.maxs = max_speed_i;
    s1_d.dt   = delta_time_i;
  end

  // Stage 2: offsets to both candidate waypoints
  a_t a2_d, a2_q, a3_q, a4_q;

  always_comb begin
    a2_d      = '0;
    a2_d.vld  = s1_q.vld;
    a2_d.func = s1_q.func;
    a2_d.idx0 = s1_q.idx0;
    a2_d.idx1 = s1_q.idx1;
    a2_d.dx0  = {wpa_x_q[31], wpa_x_q} - {s1_q.px[31], s1_q.px};
    a2_d.dy0  = {wpa_y_q[31], wpa_y_q} - {s1_q.py[31], s1_q.py};
    a2_d.dx1  = {wpb_x_q[31], wpb_x_q} - {s1_q.px[31], s1_q.px};
    a2_d.dy1  = {wpb_y_q[31], wpb_y_q} - {s1_q.py[31], s1_q.py};
    a2_d.px   = s1_q.px;
    a2_d.py   = s1_q.py;
    a2_d.vx   = s1_q.vx;
    a2_d.vy   = s1_q.vy;
    a2_d.maxs = s1_q.maxs;
    a2_d.dt   = s1_q.dt;
  end

  // Stage 3 squares, stage 4 sums of squares
  logic [63:0] sq0x_d, sq0y_d, sq1x_d, sq1y_d;
  logic [63:0] sq0x_q, sq0y_q, sq1x_q, sq1y_q;
  logic [64:0] sum0_q, sum1_q;

  assign sq0x_d = mag33(a2_q.dx0) * mag33(a2_q.dx0);
  assign sq0y_d = mag33(a2_q.dy0) * mag33(a2_q.dy0);
  assign sq1x_d = mag33(a2_q.dx1) * mag33(a2_q.dx1);
  assign sq1y_d = mag33(a2_q.dy1) * mag33(a2_q.dy1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq0x_q <= sq0x_d;
      sq0y_q <= sq0y_d;
      sq1x_q <= sq1x_d;
      sq1y_q <= sq1y_d;
      sum0_q <= {1'b0, sq0x_q} + {1'b0, sq0y_q};
      sum1_q <= {1'b0, sq1x_q} + {1'b0, sq1y_q};
    end
  end

  // Distances to both candidates
  logic [SQ_ROOTW-1:0] root0, root1, root2;
  a_t                  a_line_q [SQ_LAT];
  a_t                  al;

  wpf_sqrt u_sq_len0 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (SQ_RADW'(sum0_q)),
    .root_o (root0)
  );

  wpf_sqrt u_sq_len1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (SQ_RADW'(sum1_q)),
    .root_o (root1)
  );

  assign al = a_line_q[SQ_LAT-1];

  // Stage 5: arrival check, pick target
  b_t  b5_d, b5_q, b6_q, b7_d, b7_q, b8_q;
  logic arrive;

  always_comb begin
    arrive    = root0 < {3'b000, arrival_q};
    b5_d      = '0;
    b5_d.vld  = al.vld;
    b5_d.func = al.func;
    b5_d.idx  = arrive ? al.idx1 : al.idx0;
    b5_d.dx   = arrive ? al.dx1 : al.dx0;
    b5_d.dy   = arrive ? al.dy1 : al.dy0;
    b5_d.len  = arrive ? root1 : root0;
    b5_d.sl   = b5_d.len < {3'b000, slowing_q};
    b5_d.px   = al.px;
    b5_d.py   = al.py;
    b5_d.vx   = al.vx;
    b5_d.vy   = al.vy;
    b5_d.maxs = al.maxs;
    b5_d.dt   = al.dt;
  end

  // Stage 6: max_speed * len for the slowdown ratio
  logic [61:0] prods_q;
  logic [DIV_QW-1:0] q_speed;
  b_t  b_line_q [DIV_LAT];
  b_t  bl;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prods_q <= b5_q.maxs * b5_q.len[30:0];
    end
  end

  wpf_div u_div_speed (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({2'b00, prods_q}),
    .den_i ({3'b000, slowing_q}),
    .quo_o (q_speed)
  );

  assign bl = b_line_q[DIV_LAT-1];

  // Stage 7: desired speed
  always_comb begin
    b7_d       = bl;
    b7_d.speed = bl.sl ? q_speed : bl.maxs;
  end

  // Stage 8: offset * speed, then divide by distance
  logic [62:0] pdx_q, pdy_q;
  logic [DIV_QW-1:0] q_ex, q_ey;
  b_t  c_line_q [DIV_LAT];
  b_t  cl;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdx_q <= mag33(b7_q.dx) * b7_q.speed;
      pdy_q <= mag33(b7_q.dy) * b7_q.speed;
    end
  end

  wpf_div u_div_ex (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({1'b0, pdx_q}),
    .den_i (b8_q.len),
    .quo_o (q_ex)
  );

  wpf_div u_div_ey (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({1'b0, pdy_q}),
    .den_i (b8_q.len),
    .quo_o (q_ey)
  );

  assign cl = c_line_q[DIV_LAT-1];

  // Stage 9: signed desired velocity, zero at zero distance
  e_t  e9_d, e9_q, e10_q, e11_q;

  always_comb begin
    e9_d      = '0;
    e9_d.vld  = cl.vld;
    e9_d.func = cl.func;
    e9_d.idx  = cl.idx;
    if (cl.len != '0) begin
      e9_d.ex = cl.dx[32] ? (32'd0 - {1'b0, q_ex}) : {1'b0, q_ex};
      e9_d.ey = cl.dy[32] ? (32'd0 - {1'b0, q_ey}) : {1'b0, q_ey};
    end
    e9_d.px   = cl.px;
    e9_d.py   = cl.py;
    e9_d.vx   = cl.vx;
    e9_d.vy   = cl.vy;
    e9_d.maxs = cl.maxs;
    e9_d.dt   = cl.dt;
  end

  // Stage 10 steering, stage 11 steering * dt
  logic [32:0] diffx_q, diffy_q;
  logic [49:0] pvx_q, pvy_q;
  logic        svx_q, svy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      diffx_q <= {e9_q.ex[31], e9_q.ex} - {e9_q.vx[31], e9_q.vx};
      diffy_q <= {e9_q.ey[31], e9_q.ey} - {e9_q.vy[31], e9_q.vy};
      pvx_q   <= mag33(diffx_q) * e10_q.dt;
      pvy_q   <= mag33(diffy_q) * e10_q.dt;
      svx_q   <= diffx_q[32];
      svy_q   <= diffy_q[32];
    end
  end

  // Stage 12: integrate velocity
  g_t  g12_d, g12_q, g13_q, g14_q, g15_d, g15_q, g16_q;

  always_comb begin
    g12_d      = '0;
    g12_d.vld  = e11_q.vld;
    g12_d.func = e11_q.func;
    g12_d.idx  = e11_q.idx;
    g12_d.nx   = {{2{e11_q.vx[31]}}, e11_q.vx} +
                 (svx_q ? (34'd0 - pvx_q[49:16]) : pvx_q[49:16]);
    g12_d.ny   = {{2{e11_q.vy[31]}}, e11_q.vy} +
                 (svy_q ? (34'd0 - pvy_q[49:16]) : pvy_q[49:16]);
    g12_d.px   = e11_q.px;
    g12_d.py   = e11_q.py;
    g12_d.maxs = e11_q.maxs;
    g12_d.dt   = e11_q.dt;
  end

  // Stage 13: low-word squares of |v|, stage 14: full sum of squares
  logic [32:0] mnx, mny;
  logic [31:0] alx_q, aly_q;
  logic        ahx_q, ahy_q;
  logic [63:0] sqlx_d, sqly_d, sqlx_q, sqly_q;
  logic [67:0] fullx, fully, sum2_q;

  assign mnx    = mag34(g12_q.nx);
  assign mny    = mag34(g12_q.ny);
  assign sqlx_d = mnx[31:0] * mnx[31:0];
  assign sqly_d = mny[31:0] * mny[31:0];
  // (h*2^32 + l)^2 with h a single bit
  assign fullx  = 68'(sqlx_q) +
                  (ahx_q ? (68'({alx_q, 33'd0}) + 68'h10000000000000000) : 68'd0);
  assign fully  = 68'(sqly_q) +
                  (ahy_q ? (68'({aly_q, 33'd0}) + 68'h10000000000000000) : 68'd0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      alx_q  <= mnx[31:0];
      aly_q  <= mny[31:0];
      ahx_q  <= mnx[32];
      ahy_q  <= mny[32];
      sqlx_q <= sqlx_d;
      sqly_q <= sqly_d;
      sum2_q <= fullx + fully;
    end
  end

  // Speed of the new velocity
  g_t  g_line_q [SQ_LAT];
  g_t  gl;

  wpf_sqrt u_sq_vel (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum2_q),
    .root_o (root2)
  );

  assign gl = g_line_q[SQ_LAT-1];

  // Stage 15: clamp decision
  logic [SQ_ROOTW-1:0] nl_q;

  always_comb begin
    g15_d       = gl;
    g15_d.clamp = root2 > {3'b000, gl.maxs};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nl_q <= root2;
    end
  end

  // Stage 16: |v| * max_speed, then divide by speed
  logic [63:0] pfx_q, pfy_q;
  logic [SQ_ROOTW-1:0] nl16_q;
  logic [DIV_QW-1:0] q_nx, q_ny;
  g_t  h_line_q [DIV_LAT];
  g_t  hl;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pfx_q  <= mag34(g15_q.nx) * g15_q.maxs;
      pfy_q  <= mag34(g15_q.ny) * g15_q.maxs;
      nl16_q <= nl_q;
    end
  end

  wpf_div u_div_nx (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (pfx_q),
    .den_i (nl16_q),
    .quo_o (q_nx)
  );

  wpf_div u_div_ny (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (pfy_q),
    .den_i (nl16_q),
    .quo_o (q_ny)
  );

  assign hl = h_line_q[DIV_LAT-1];

  // Stage 17: clamped velocity
  i_t  i17_d, i17_q, i18_q;

  always_comb begin
    i17_d      = '0;
    i17_d.vld  = hl.vld;
    i17_d.func = hl.func;
    i17_d.idx  = hl.idx;
    if (hl.clamp) begin
      i17_d.fx = hl.nx[33] ? (32'd0 - {1'b0, q_nx}) : {1'b0, q_nx};
      i17_d.fy = hl.ny[33] ? (32'd0 - {1'b0, q_ny}) : {1'b0, q_ny};
    end else begin
      i17_d.fx = hl.nx[31:0];
      i17_d.fy = hl.ny[31:0];
    end
    i17_d.px = hl.px;
    i17_d.py = hl.py;
    i17_d.dt = hl.dt;
  end

  // Stage 18: velocity * dt
  logic [49:0] pox_q, poy_q;
  logic        sox_q, soy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pox_q <= mag32(i17_q.fx) * i17_q.dt;
      poy_q <= mag32(i17_q.fy) * i17_q.dt;
      sox_q <= i17_q.fx[31];
      soy_q <= i17_q.fy[31];
    end
  end

  // Stage 19: position update and output register
  logic        out_valid_q;
  logic [31:0] opx_q, opy_q, ovx_q, ovy_q;
  logic [3:0]  oidx_q;
  logic [34:0] posx_sum, posy_sum;

  assign posx_sum = {{3{i18_q.px[31]}}, i18_q.px} +
                    (sox_q ? (35'd0 - {1'b0, pox_q[49:16]}) : {1'b0, pox_q[49:16]});
  assign posy_sum = {{3{i18_q.py[31]}}, i18_q.py} +
                    (soy_q ? (35'd0 - {1'b0, poy_q[49:16]}) : {1'b0, poy_q[49:16]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= i18_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (i18_q.func == FUNC_STEP) begin
        opx_q  <= sat35(posx_sum);
        opy_q  <= sat35(posy_sum);
        ovx_q  <= i18_q.fx;
        ovy_q  <= i18_q.fy;
        oidx_q <= i18_q.idx;
      end else begin
        opx_q  <= '0;
        opy_q  <= '0;
        ovx_q  <= '0;
        ovy_q  <= '0;
        oidx_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: all stages move together
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      a2_q  <= '0;
      a3_q  <= '0;
      a4_q  <= '0;
      b5_q  <= '0;
      b6_q  <= '0;
      b7_q  <= '0;
      b8_q  <= '0;
      e9_q  <= '0;
      e10_q <= '0;
      e11_q <= '0;
      g12_q <= '0;
      g13_q <= '0;
      g14_q <= '0;
      g15_q <= '0;
      g16_q <= '0;
      i17_q <= '0;
      i18_q <= '0;
    end else if (en) begin
      s1_q  <= s1_d;
      a2_q  <= a2_d;
      a3_q  <= a2_q;
      a4_q  <= a3_q;
      b5_q  <= b5_d;
      b6_q  <= b5_q;
      b7_q  <= b7_d;
      b8_q  <= b7_q;
      e9_q  <= e9_d;
      e10_q <= e9_q;
      e11_q <= e10_q;
      g12_q <= g12_d;
      g13_q <= g12_q;
      g14_q <= g13_q;
      g15_q <= g15_d;
      g16_q <= g15_q;
      i17_q <= i17_d;
      i18_q <= i17_q;
    end
  end

  // Side lines matched to the square-root and divider latencies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_LAT; k++) begin
        a_line_q[k] <= '0;
        g_line_q[k] <= '0;
      end
      for (int k = 0; k < DIV_LAT; k++) begin
        b_line_q[k] <= '0;
        c_line_q[k] <= '0;
        h_line_q[k] <= '0;
      end
    end else if (en) begin
      a_line_q[0] <= a4_q;
      g_line_q[0] <= g14_q;
      b_line_q[0] <= b6_q;
      c_line_q[0] <= b8_q;
      h_line_q[0] <= g16_q;
      for (int k = 1; k < SQ_LAT; k++) begin
        a_line_q[k] <= a_line_q[k-1];
        g_line_q[k] <= g_line_q[k-1];
      end
      for (int k = 1; k < DIV_LAT; k++) begin
        b_line_q[k] <= b_line_q[k-1];
        c_line_q[k] <= c_line_q[k-1];
        h_line_q[k] <= h_line_q[k-1];
      end
    end
  end

  // Outputs
  assign out_valid_o           = out_valid_q;
  assign new_pos_x_o           = opx_q;
  assign new_pos_y_o           = opy_q;
  assign new_vel_x_o           = ovx_q;
  assign new_vel_y_o           = ovy_q;
  assign next_waypoint_index_o = oidx_q;

  // ---------------------------------------------------------------------
  // Assertions

  // distance to the current waypoint is at least each offset component
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (al.vld && al.func == FUNC_STEP) |->
      (root0 >= {2'b00, mag33(al.dx0)}) && (root0 >= {2'b00, mag33(al.dy0)}))
    else $error("distance root below offset component");

  // desired velocity components never exceed the desired speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cl.vld && cl.func == FUNC_STEP && cl.len != '0) |->
      (q_ex <= cl.speed) && (q_ey <= cl.speed))
    else $error("desired velocity exceeds desired speed");

  // clamped velocity components stay within max speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hl.vld && hl.func == FUNC_STEP && hl.clamp) |->
      (q_nx <= hl.maxs) && (q_ny <= hl.maxs))
    else $error("clamped velocity exceeds max speed");

endmodule

FILE: sv/wpf_sqrt.sv
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage.
module wpf_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [wpf_pkg::SQ_RADW-1:0]  rad_i,
  output logic [wpf_pkg::SQ_ROOTW-1:0] root_o
);
  import wpf_pkg::*;

  logic [SQ_RADW-1:0]  rad_q  [SQ_LAT];
  logic [SQ_REMW-1:0]  rem_q  [SQ_LAT];
  logic [SQ_ROOTW-1:0] root_q [SQ_LAT];

  for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
    logic [SQ_RADW-1:0]  rad_in;
    logic [SQ_REMW-1:0]  rem_in;
    logic [SQ_ROOTW-1:0] root_in;
    logic [SQ_REMW-1:0]  cur;
    logic [SQ_REMW-1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {rem_in[SQ_REMW-3:0], rad_in[SQ_RADW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k] <= {rad_in[SQ_RADW-3:0], 2'b00};
        if (cur >= trial) begin
          rem_q[k]  <= cur - trial;
          root_q[k] <= {root_in[SQ_ROOTW-2:0], 1'b1};
        end else begin
          rem_q[k]  <= cur;
          root_q[k] <= {root_in[SQ_ROOTW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SQ_LAT-1];

endmodule

FILE: sv/wpf_div.sv
// Pipelined restoring divider, floor(num/den) for quotients below 2^31.
module wpf_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [wpf_pkg::DIV_NUMW-1:0] num_i,
  input  logic [wpf_pkg::DIV_DENW-1:0] den_i,
  output logic [wpf_pkg::DIV_QW-1:0]   quo_o
);
  import wpf_pkg::*;

  logic [DIV_QW-1:0]   lo_q  [DIV_LAT];
  logic [DIV_DENW-1:0] rem_q [DIV_LAT];
  logic [DIV_DENW-1:0] den_q [DIV_LAT];
  logic [DIV_QW-1:0]   quo_q [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DIV_QW-1:0]   lo_in;
    logic [DIV_DENW-1:0] rem_in;
    logic [DIV_DENW-1:0] den_in;
    logic [DIV_QW-1:0]   quo_in;
    logic [DIV_DENW:0]   cur;
    logic [DIV_DENW:0]   diff;

    if (k == 0) begin : g_first
      // upper numerator bits are below the divisor when the quotient fits
      assign rem_in = DIV_DENW'(num_i[DIV_NUMW-1:DIV_QW]);
      assign lo_in  = num_i[DIV_QW-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign cur  = {rem_in, lo_in[DIV_QW-1]};
    assign diff = cur - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[k]  <= {lo_in[DIV_QW-2:0], 1'b0};
        den_q[k] <= den_in;
        if (cur >= {1'b0, den_in}) begin
          rem_q[k] <= diff[DIV_DENW-1:0];
          quo_q[k] <= {quo_in[DIV_QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= cur[DIV_DENW-1:0];
          quo_q[k] <= {quo_in[DIV_QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule
